// ===== sv/twmp_pkg.sv =====
// Package for the timed window motor positioner: field widths, codes, motion states,
// the controller state type and the command/status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package twmp_pkg;

    localparam int unsigned TICK_MS_DEF = 10;

    localparam int unsigned TRAVEL_W   = 16;
    localparam int unsigned DUTY_W     = 10;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned ELAPSED_W  = 20;
    localparam int unsigned PCT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Serial divider sizing. Every dividend stays below divisor * 2**QUOT_W.
    localparam int unsigned DIVIDEND_W = 23;
    localparam int unsigned QUOT_W     = 16;
    localparam int unsigned DIV_STEPS  = QUOT_W;

    localparam logic [POS_W-1:0]  FULL_POS     = 7'd100;
    localparam logic [POS_W-1:0]  PINCH_TARGET = 7'd70;
    localparam logic [DUTY_W-1:0] DUTY_MAX     = 10'd1000;
    localparam logic [PCT_W-1:0]  PCT_MAX      = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TRAVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TRAVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DUTY   = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] BTN_OPEN   = 2'd0;
    localparam logic [1:0] BTN_CLOSE  = 2'd2;
    localparam logic [1:0] SDIR_CLOSE = 2'd1;
    localparam logic [1:0] SDIR_OPEN  = 2'd2;

    typedef enum logic [1:0] {
        MOT_STOP  = 2'd0,
        MOT_CLOSE = 2'd1,
        MOT_OPEN  = 2'd2
    } t_motion;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic tick_add;
        logic tick_chk;
        logic eval;
        logic apply_q;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic moving;
        logic tick_sat;
        logic eval_move;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/twmp_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on twmp_pkg for operand widths and step count.
`timescale 1ns / 1ps

module twmp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [twmp_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [twmp_pkg::TRAVEL_W-1:0]   i_divisor,
    output logic                            o_done,
    output logic [twmp_pkg::QUOT_W-1:0]     o_quot
);
    import twmp_pkg::*;

    localparam int unsigned DSH_W = TRAVEL_W + QUOT_W - 1;
    localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIVIDEND_W-1:0] r_rem;
    logic [DSH_W-1:0]      r_dsh;
    logic [QUOT_W-1:0]     r_quot;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  fits;

    assign fits   = {{(DSH_W-DIVIDEND_W){1'b0}}, r_rem} >= r_dsh;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= {i_divisor, {(QUOT_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[DIVIDEND_W-1:0];
            end
            r_quot <= {r_quot[QUOT_W-2:0], fits};
            r_dsh  <= r_dsh >> 1;
        end
    end

endmodule

// ===== sv/twmp_dpath.sv =====
// Datapath: configuration registers, position and timing state, event latches,
// decision logic, the serial divider and the output register. Uses twmp_pkg and twmp_div.
`timescale 1ns / 1ps

module twmp_dpath #(
    parameter int unsigned TICK_MS = twmp_pkg::TICK_MS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  twmp_pkg::t_cmd                  i_cmd,
    output twmp_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_we,
    input  logic [twmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_op,
    input  logic                            i_pinch_arrives,
    input  logic                            i_pinch_level,
    input  logic                            i_driver_arrives,
    input  logic [1:0]                      i_driver_button,
    input  logic                            i_smart_arrives,
    input  logic [1:0]                      i_smart_direction,
    input  logic [twmp_pkg::PCT_W-1:0]      i_smart_percent,
    input  logic                            i_power_on,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [1:0]                      o_motion,
    output logic                            o_direction_pin,
    output logic [twmp_pkg::DUTY_W-1:0]     o_pwm_compare,
    output logic [twmp_pkg::POS_W-1:0]      o_position
);
    import twmp_pkg::*;

    logic [TRAVEL_W-1:0]   r_open_travel;
    logic [TRAVEL_W-1:0]   r_close_travel;
    logic [DUTY_W-1:0]     r_duty;
    t_motion               r_motion;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_target;
    logic [2:0]            r_pend;
    logic                  r_pinch_level;
    logic [1:0]            r_button;
    logic [1:0]            r_sdir;
    logic [PCT_W-1:0]      r_spct;
    logic                  r_dir;
    logic                  r_op;
    logic                  r_power;
    logic                  r_div_move;
    logic                  r_out_valid;
    logic [1:0]            r_out_motion;
    logic                  r_out_dir;
    logic [DUTY_W-1:0]     r_out_pwm;
    logic [POS_W-1:0]      r_out_pos;

    logic [TRAVEL_W-1:0]   open_div;
    logic [TRAVEL_W-1:0]   close_div;
    logic [TRAVEL_W-1:0]   sel_travel;
    logic [ELAPSED_W:0]    elapsed_sum;
    logic [ELAPSED_W-1:0]  elapsed_sat;
    logic                  tick_sat;
    logic                  opening;
    logic                  stopped;
    logic [DIVIDEND_W-1:0] tick_dividend;
    logic [DIVIDEND_W-1:0] move_dividend;
    logic [POS_W-1:0]      frac;
    logic [POS_W-1:0]      new_pos;
    logic                  tick_halt;
    logic                  tick_apply;
    logic [DUTY_W-1:0]     duty_lim;
    logic [POS_W-1:0]      pct_clamped;
    logic [2:0]            e_clear;
    logic                  e_halt;
    logic                  e_open;
    logic                  e_close;
    logic [POS_W-1:0]      e_target;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [TRAVEL_W-1:0]   div_divisor;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;

    assign open_div   = (r_open_travel == '0) ? TRAVEL_W'(1) : r_open_travel;
    assign close_div  = (r_close_travel == '0) ? TRAVEL_W'(1) : r_close_travel;
    assign opening    = (r_motion == MOT_OPEN);
    assign stopped    = (r_motion == MOT_STOP);
    assign sel_travel = opening ? open_div : close_div;

    assign elapsed_sum = {1'b0, r_elapsed} + (ELAPSED_W+1)'(TICK_MS);
    assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

    // The scaled fraction reaches full travel exactly when elapsed time reaches travel time,
    // so below that point elapsed time fits the travel width.
    assign tick_sat      = r_elapsed >= {{(ELAPSED_W-TRAVEL_W){1'b0}}, sel_travel};
    assign tick_dividend = DIVIDEND_W'(r_elapsed[TRAVEL_W-1:0]) * DIVIDEND_W'(FULL_POS);

    assign frac       = tick_sat ? FULL_POS : div_quot[POS_W-1:0];
    assign new_pos    = opening ? (FULL_POS - frac) : frac;
    assign tick_halt  = opening ? (new_pos <= r_target) : (new_pos >= r_target);
    assign tick_apply = (i_cmd.tick_chk && tick_sat) || (i_cmd.apply_q && !r_div_move);

    assign duty_lim    = (r_duty > DUTY_MAX) ? DUTY_MAX : r_duty;
    assign pct_clamped = (r_spct > PCT_MAX) ? FULL_POS : r_spct[POS_W-1:0];

    // At most one pending event is consumed per evaluation, pinch first. A pinch whose level is
    // low stays pending and lets the lower priorities through.
    always_comb begin
        e_clear  = 3'b000;
        e_halt   = 1'b0;
        e_open   = 1'b0;
        e_close  = 1'b0;
        e_target = r_target;
        if (r_pend[0] && r_pinch_level) begin
            e_clear  = 3'b001;
            e_open   = 1'b1;
            e_target = PINCH_TARGET;
        end else if (r_pend[1]) begin
            e_clear = 3'b010;
            case (r_button)
                BTN_OPEN: begin
                    e_open   = stopped;
                    e_target = '0;
                end
                BTN_CLOSE: begin
                    e_close  = stopped;
                    e_target = FULL_POS;
                end
                default: e_halt = 1'b1;
            endcase
        end else if (r_pend[2]) begin
            e_clear  = 3'b100;
            e_target = pct_clamped;
            case (r_sdir)
                SDIR_OPEN:  e_open  = stopped;
                SDIR_CLOSE: e_close = stopped;
                default:    ;
            endcase
        end else begin
            e_halt = !r_power;
        end
    end

    assign move_dividend = e_open ? (DIVIDEND_W'(FULL_POS - r_pos) * DIVIDEND_W'(r_open_travel))
                                  : (DIVIDEND_W'(r_pos) * DIVIDEND_W'(r_close_travel));

    assign div_start    = (i_cmd.eval && (e_open || e_close)) || (i_cmd.tick_chk && !tick_sat);
    assign div_dividend = i_cmd.eval ? move_dividend : tick_dividend;
    assign div_divisor  = i_cmd.eval ? TRAVEL_W'(FULL_POS) : sel_travel;

    twmp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_travel  <= TRAVEL_W'(5000);
            r_close_travel <= TRAVEL_W'(5000);
            r_duty         <= DUTY_W'(800);
            r_motion       <= MOT_STOP;
            r_elapsed      <= '0;
            r_pos          <= '0;
            r_target       <= FULL_POS;
            r_pend         <= 3'b000;
            r_pinch_level  <= 1'b0;
            r_button       <= '0;
            r_sdir         <= '0;
            r_spct         <= '0;
            r_dir          <= 1'b0;
            r_div_move     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OPEN_TRAVEL:  r_open_travel  <= i_cfg_data;
                    REG_CLOSE_TRAVEL: r_close_travel <= i_cfg_data;
                    REG_DRIVE_DUTY:   r_duty         <= i_cfg_data[DUTY_W-1:0];
                    default:          ;
                endcase
            end

            if (i_cmd.accept) begin
                if (i_pinch_arrives) begin
                    r_pend[0]     <= 1'b1;
                    r_pinch_level <= i_pinch_level;
                end
                if (i_driver_arrives) begin
                    r_pend[1] <= 1'b1;
                    r_button  <= i_driver_button;
                end
                if (i_smart_arrives) begin
                    r_pend[2] <= 1'b1;
                    r_sdir    <= i_smart_direction;
                    r_spct    <= i_smart_percent;
                end
            end

            if (i_cmd.tick_add) begin
                r_elapsed <= elapsed_sat;
            end

            if (i_cmd.tick_chk) begin
                r_div_move <= 1'b0;
            end

            if (tick_apply) begin
                r_pos <= new_pos;
                if (tick_halt) begin
                    r_motion  <= MOT_STOP;
                    r_elapsed <= '0;
                end
            end

            if (i_cmd.eval) begin
                r_pend     <= r_pend & ~e_clear;
                r_div_move <= 1'b1;
                if (e_halt) begin
                    r_motion  <= MOT_STOP;
                    r_elapsed <= '0;
                end
                if (e_open) begin
                    r_motion <= MOT_OPEN;
                    r_target <= e_target;
                    r_dir    <= 1'b1;
                end
                if (e_close) begin
                    r_motion <= MOT_CLOSE;
                    r_target <= e_target;
                    r_dir    <= 1'b0;
                end
            end

            if (i_cmd.apply_q && r_div_move) begin
                r_elapsed <= ELAPSED_W'(div_quot);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_power <= i_power_on;
        end
        if (i_cmd.out_load) begin
            r_out_motion <= r_motion;
            r_out_dir    <= r_dir;
            r_out_pwm    <= stopped ? '0 : duty_lim;
            r_out_pos    <= r_pos;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.moving    = !stopped;
    assign o_sts.tick_sat  = tick_sat;
    assign o_sts.eval_move = e_open || e_close;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_motion        = r_out_motion;
    assign o_direction_pin = r_out_dir;
    assign o_pwm_compare   = r_out_pwm;
    assign o_position      = r_out_pos;

endmodule

// ===== sv/twmp_ctrl.sv =====
// Controller state machine: sequences acceptance, tick update, evaluation, division
// and result hand-off. Depends on twmp_pkg for the state, command and status types.
`timescale 1ns / 1ps

module twmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  twmp_pkg::t_sts i_sts,
    output twmp_pkg::t_cmd o_cmd
);
    import twmp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.op == OP_TICK) begin
                    n_state = i_sts.moving ? ST_CHECK : ST_OUTPUT;
                end else begin
                    n_state = i_sts.eval_move ? ST_DIVIDE : ST_OUTPUT;
                end
            end
            ST_CHECK: begin
                n_state = i_sts.tick_sat ? ST_OUTPUT : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_sts.div_done) n_state = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.tick_add = (i_sts.op == OP_TICK) && i_sts.moving;
                o_cmd.eval     = (i_sts.op == OP_EVAL);
            end
            ST_CHECK:  o_cmd.tick_chk = 1'b1;
            ST_DIVIDE: o_cmd.apply_q  = i_sts.div_done;
            ST_OUTPUT: o_cmd.out_load = i_sts.out_free;
            default:   ;
        endcase
    end

endmodule

// ===== sv/timed_window_motor_positioner_core.sv =====
// Top level of the timed window motor positioner: controller plus datapath.
// Depends on twmp_pkg, twmp_ctrl, twmp_dpath and twmp_div.
`timescale 1ns / 1ps

// One word in gives one result word out. Words are taken one at a time: a control
// evaluation that starts a move, and a tick of a moving motor whose estimate has not
// reached full travel, both run the 16-step restoring divider that scales elapsed time
// against travel time (or the start product by 100). Other words go from the decide state
// straight to output, a tick that reaches full travel by way of the check state.
// The input opens again in the cycle after the result is loaded; a result still stalled
// at the output holds the next one, and with it the input, until it is taken. A finished
// result waits in the output register while the next word is accepted. Configuration
// writes take effect at the clock edge of the write; pwm_compare reflects drive_duty,
// limited to 1000, at the moment the result is formed.
module timed_window_motor_positioner_core #(
    parameter int unsigned TICK_MS = twmp_pkg::TICK_MS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic                            i_pinch_arrives,
    input  logic                            i_pinch_level,
    input  logic                            i_driver_arrives,
    input  logic [1:0]                      i_driver_button,
    input  logic                            i_smart_arrives,
    input  logic [1:0]                      i_smart_direction,
    input  logic [twmp_pkg::PCT_W-1:0]      i_smart_percent,
    input  logic                            i_power_on,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_motion,
    output logic                            o_direction_pin,
    output logic [twmp_pkg::DUTY_W-1:0]     o_pwm_compare,
    output logic [twmp_pkg::POS_W-1:0]      o_position,
    input  logic                            i_cfg_we,
    input  logic [twmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twmp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import twmp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    twmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    twmp_dpath #(
        .TICK_MS (TICK_MS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_pinch_arrives   (i_pinch_arrives),
        .i_pinch_level     (i_pinch_level),
        .i_driver_arrives  (i_driver_arrives),
        .i_driver_button   (i_driver_button),
        .i_smart_arrives   (i_smart_arrives),
        .i_smart_direction (i_smart_direction),
        .i_smart_percent   (i_smart_percent),
        .i_power_on        (i_power_on),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_motion          (o_motion),
        .o_direction_pin   (o_direction_pin),
        .o_pwm_compare     (o_pwm_compare),
        .o_position        (o_position)
    );

    // An accepted word keeps the input side closed until its result is formed.
    a_accept_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again before the previous word finished");

    // A new result only appears while a word is in progress.
    a_result_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a word in progress");

    a_stopped_no_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_motion == MOT_STOP)) |-> (o_pwm_compare == '0))
        else $error("nonzero PWM compare reported while stopped");

    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position <= FULL_POS))
        else $error("position estimate beyond full travel");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for timed_window_motor_positioner_core: a directed table, then
// random words under several register settings, checked against a behavioral predictor.
// Depends on twmp_pkg and timed_window_motor_positioner_core.
`timescale 1ns / 1ps

module tb;
    import twmp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] BTN_STOP      = 2'd1;
    localparam logic [1:0] BTN_STOP_ALT  = 2'd3;
    localparam logic [1:0] SDIR_IDLE     = 2'd0;
    localparam logic [1:0] SDIR_IDLE_ALT = 2'd3;
    localparam logic [ELAPSED_W-1:0] RUN_MS_MAX = 20'hFFFFF;
    localparam int PHASES        = 6;
    localparam int WORDS_PER_PHASE = 190;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic              op;
        logic              pinch_arrives;
        logic              pinch_level;
        logic              driver_arrives;
        logic [1:0]        driver_button;
        logic              smart_arrives;
        logic [1:0]        smart_direction;
        logic [PCT_W-1:0]  smart_percent;
        logic              power_on;
    } t_window_word;

    typedef struct packed {
        t_motion           motion;
        logic              direction;
        logic [DUTY_W-1:0] pwm;
        logic [POS_W-1:0]  position;
    } t_window_status;

    typedef struct packed {
        t_window_word   word;
        logic           has_status;
        t_window_status status;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic                  i_pinch_arrives;
    logic                  i_pinch_level;
    logic                  i_driver_arrives;
    logic [1:0]            i_driver_button;
    logic                  i_smart_arrives;
    logic [1:0]            i_smart_direction;
    logic [PCT_W-1:0]      i_smart_percent;
    logic                  i_power_on;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_motion;
    logic                  o_direction_pin;
    logic [DUTY_W-1:0]     o_pwm_compare;
    logic [POS_W-1:0]      o_position;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    timed_window_motor_positioner_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_pinch_arrives   (i_pinch_arrives),
        .i_pinch_level     (i_pinch_level),
        .i_driver_arrives  (i_driver_arrives),
        .i_driver_button   (i_driver_button),
        .i_smart_arrives   (i_smart_arrives),
        .i_smart_direction (i_smart_direction),
        .i_smart_percent   (i_smart_percent),
        .i_power_on        (i_power_on),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_motion          (o_motion),
        .o_direction_pin   (o_direction_pin),
        .o_pwm_compare     (o_pwm_compare),
        .o_position        (o_position),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Predictor copy of the registers and of the positioner state.
    logic [TRAVEL_W-1:0]  open_ms;
    logic [TRAVEL_W-1:0]  close_ms;
    logic [DUTY_W-1:0]    duty_setting;
    t_motion              m_motion;
    logic [ELAPSED_W-1:0] m_run_ms;
    logic [POS_W-1:0]     m_pos;
    logic [POS_W-1:0]     m_target;
    logic                 m_dir;
    logic                 pend_pinch;
    logic                 pend_override;
    logic                 pend_smart;
    logic                 held_pinch_level;
    logic [1:0]           held_button;
    logic [1:0]           held_sdir;
    logic [PCT_W-1:0]     held_spct;

    t_window_status window_status_q[$];
    t_stim_row      stim_rows[$];
    int             send_idle_pct;
    int             recv_stall_pct;
    int             err_count = 0;
    int unsigned    cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void halt_window();
        m_motion = MOT_STOP;
        m_run_ms = '0;
    endfunction

    // A move only starts from stopped; the elapsed time is preset so that the
    // estimate continues from the current position.
    function automatic void begin_travel(input logic opening, input logic [PCT_W-1:0] pct);
        logic [POS_W-1:0] goal;
        logic [63:0]      prod;
        goal = (pct > PCT_MAX) ? FULL_POS : pct[POS_W-1:0];
        if (m_motion != MOT_STOP) return;
        m_target = goal;
        if (opening) begin
            m_motion = MOT_OPEN;
            prod = 64'(FULL_POS - m_pos);
            prod = prod * 64'(open_ms) / 100;
            m_dir = 1'b1;
        end else begin
            m_motion = MOT_CLOSE;
            prod = 64'(m_pos);
            prod = prod * 64'(close_ms) / 100;
            m_dir = 1'b0;
        end
        m_run_ms = prod[ELAPSED_W-1:0];
    endfunction

    function automatic void tick_window();
        logic [63:0] run;
        logic [63:0] span;
        logic [63:0] frac;
        if (m_motion == MOT_STOP) return;
        run = 64'(m_run_ms);
        run = run + 64'(TICK_MS_DEF);
        if (run > 64'(RUN_MS_MAX)) run = 64'(RUN_MS_MAX);
        m_run_ms = run[ELAPSED_W-1:0];
        if (m_motion == MOT_OPEN) begin
            span = (open_ms == '0) ? 64'd1 : 64'(open_ms);
            frac = run * 100 / span;
            m_pos = (frac >= 100) ? '0 : FULL_POS - frac[POS_W-1:0];
            if (m_pos <= m_target) halt_window();
        end else begin
            span = (close_ms == '0) ? 64'd1 : 64'(close_ms);
            frac = run * 100 / span;
            m_pos = (frac >= 100) ? FULL_POS : frac[POS_W-1:0];
            if (m_pos >= m_target) halt_window();
        end
    endfunction

    // At most one pending event is consumed, pinch first; a pinch held at low
    // level stays pending and lets the lower events through.
    function automatic void evaluate_window(input logic power);
        if (pend_pinch && held_pinch_level) begin
            halt_window();
            begin_travel(1'b1, {1'b0, PINCH_TARGET});
            pend_pinch = 1'b0;
        end else if (pend_override) begin
            if (held_button == BTN_OPEN) begin
                begin_travel(1'b1, '0);
            end else if (held_button == BTN_CLOSE) begin
                begin_travel(1'b0, PCT_MAX);
            end else begin
                halt_window();
            end
            pend_override = 1'b0;
        end else if (pend_smart) begin
            if (held_sdir == SDIR_OPEN) begin
                begin_travel(1'b1, held_spct);
            end else if (held_sdir == SDIR_CLOSE) begin
                begin_travel(1'b0, held_spct);
            end
            pend_smart = 1'b0;
        end else if (!power) begin
            halt_window();
        end
    endfunction

    function automatic t_window_status next_window_status(input t_window_word w);
        t_window_status s;
        if (w.pinch_arrives) begin
            pend_pinch = 1'b1;
            held_pinch_level = w.pinch_level;
        end
        if (w.driver_arrives) begin
            pend_override = 1'b1;
            held_button = w.driver_button;
        end
        if (w.smart_arrives) begin
            pend_smart = 1'b1;
            held_sdir = w.smart_direction;
            held_spct = w.smart_percent;
        end
        if (w.op == OP_TICK) begin
            tick_window();
        end else begin
            evaluate_window(w.power_on);
        end
        s.motion = m_motion;
        s.direction = m_dir;
        if (m_motion == MOT_STOP) begin
            s.pwm = '0;
        end else begin
            s.pwm = (duty_setting > DUTY_MAX) ? DUTY_MAX : duty_setting;
        end
        s.position = m_pos;
        return s;
    endfunction

    function automatic void add_row(input logic op, input logic pa, input logic pl,
                                    input logic da, input logic [1:0] db, input logic sa,
                                    input logic [1:0] sd, input logic [PCT_W-1:0] sp,
                                    input logic pw, input logic typed, input t_motion mo,
                                    input logic dir, input logic [DUTY_W-1:0] pwm,
                                    input logic [POS_W-1:0] pos);
        t_stim_row r;
        r.word = '{op, pa, pl, da, db, sa, sd, sp, pw};
        r.has_status = typed;
        r.status = '{mo, dir, pwm, pos};
        stim_rows.push_back(r);
    endfunction

    function automatic t_window_word random_word();
        t_window_word w;
        w.op = ($urandom_range(0, 99) < 60) ? OP_TICK : OP_EVAL;
        w.pinch_arrives = ($urandom_range(0, 99) < 6);
        w.pinch_level = 1'($urandom_range(0, 1));
        w.driver_arrives = ($urandom_range(0, 99) < 12);
        w.driver_button = 2'($urandom_range(0, 3));
        w.smart_arrives = ($urandom_range(0, 99) < 12);
        w.smart_direction = 2'($urandom_range(0, 3));
        w.smart_percent = ($urandom_range(0, 1) != 0) ? PCT_W'($urandom_range(0, 100))
                                                       : PCT_W'($urandom_range(0, 255));
        w.power_on = ($urandom_range(0, 99) < 90);
        return w;
    endfunction

    task automatic send_word(input t_window_word w, input logic typed,
                             input t_window_status typed_status);
        int gap;
        t_window_status predicted;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= w.op;
        i_pinch_arrives   <= w.pinch_arrives;
        i_pinch_level     <= w.pinch_level;
        i_driver_arrives  <= w.driver_arrives;
        i_driver_button   <= w.driver_button;
        i_smart_arrives   <= w.smart_arrives;
        i_smart_direction <= w.smart_direction;
        i_smart_percent   <= w.smart_percent;
        i_power_on        <= w.power_on;
        do @(posedge i_clk); while (o_in_stall);
        predicted = next_window_status(w);
        window_status_q.push_back(typed ? typed_status : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_OPEN_TRAVEL:  open_ms = data;
            REG_CLOSE_TRAVEL: close_ms = data;
            REG_DRIVE_DUTY:   duty_setting = data[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Holds the input side off until every expected word has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (window_status_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_window_status want;
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (window_status_q.size() == 0) begin
                $display("%0t: unexpected result word, motion %0d position %0d",
                         $time, o_motion, o_position);
                err_count++;
            end else begin
                want = window_status_q.pop_front();
                if (o_motion !== want.motion) begin
                    $display("%0t: motion expected %0d, got %0d", $time, want.motion, o_motion);
                    err_count++;
                end
                if (o_direction_pin !== want.direction) begin
                    $display("%0t: direction_pin expected %0d, got %0d",
                             $time, want.direction, o_direction_pin);
                    err_count++;
                end
                if (o_pwm_compare !== want.pwm) begin
                    $display("%0t: pwm_compare expected %0d, got %0d",
                             $time, want.pwm, o_pwm_compare);
                    err_count++;
                end
                if (o_position !== want.position) begin
                    $display("%0t: position expected %0d, got %0d",
                             $time, want.position, o_position);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_window_status none;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_TICK;
        i_pinch_arrives = 1'b0;
        i_pinch_level = 1'b0;
        i_driver_arrives = 1'b0;
        i_driver_button = BTN_OPEN;
        i_smart_arrives = 1'b0;
        i_smart_direction = SDIR_IDLE;
        i_smart_percent = '0;
        i_power_on = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_OPEN_TRAVEL;
        i_cfg_data = '0;
        none = '0;
        send_idle_pct = 16;
        recv_stall_pct = 67;

        open_ms = 16'd5000;
        close_ms = 16'd5000;
        duty_setting = 10'd800;
        m_motion = MOT_STOP;
        m_run_ms = '0;
        m_pos = '0;
        m_target = FULL_POS;
        m_dir = 1'b0;
        pend_pinch = 1'b0;
        pend_override = 1'b0;
        pend_smart = 1'b0;
        held_pinch_level = 1'b0;
        held_button = BTN_OPEN;
        held_sdir = SDIR_IDLE;
        held_spct = '0;

        // Directed part, run with the reset register values.
        add_row(OP_TICK, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 0, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 1, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_STOP, 0, 0, 0);
        // The low pinch stays pending; the release below is taken instead.
        add_row(OP_EVAL, 0, 0, 1, BTN_STOP, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 1, 1, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_OPEN, 1, 800, 0);
        add_row(OP_TICK, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_STOP, 1, 0, 0);
        add_row(OP_EVAL, 0, 0, 1, BTN_CLOSE, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_CLOSE, 0, 800, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 1, SDIR_OPEN, 8'd255, 1, 1, MOT_CLOSE, 0, 800, 0);
        add_row(OP_TICK, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 0, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 1, SDIR_CLOSE, 8'd255, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 1, BTN_STOP_ALT, 0, SDIR_IDLE, 8'd0, 1, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 1, SDIR_IDLE, 8'd50, 1, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 1, SDIR_IDLE_ALT, 8'd0, 1, 1, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 1, 0, 0, BTN_OPEN, 1, SDIR_OPEN, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 1, 1, 1, BTN_OPEN, 1, SDIR_CLOSE, 8'd10, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 0, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 1, BTN_CLOSE, 0, SDIR_IDLE, 8'd0, 0, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_TICK, 1, 1, 0, BTN_OPEN, 1, SDIR_CLOSE, 8'd200, 1, 0, MOT_STOP, 0, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, BTN_OPEN, 0, SDIR_IDLE, 8'd0, 1, 0, MOT_STOP, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            send_word(stim_rows[k].word, stim_rows[k].has_status, stim_rows[k].status);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 16;
                recv_stall_pct = 67;
            end else if (phase < 4) begin
                send_idle_pct = 67;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            // Registers change only here, with nothing in flight; the motor
            // itself may still be moving, so a duty change shows up live.
            case (phase)
                0: begin
                    write_reg(REG_OPEN_TRAVEL, 16'd100);
                    write_reg(REG_CLOSE_TRAVEL, 16'd100);
                    write_reg(REG_DRIVE_DUTY, 16'd0);
                end
                1: begin
                    write_reg(REG_OPEN_TRAVEL, 16'd300);
                    write_reg(REG_CLOSE_TRAVEL, 16'd150);
                    write_reg(REG_DRIVE_DUTY, {6'd0, DUTY_MAX});
                end
                2: begin
                    // Zero travel counts as one millisecond; duty above the limit is capped.
                    write_reg(REG_OPEN_TRAVEL, 16'd0);
                    write_reg(REG_CLOSE_TRAVEL, 16'd0);
                    write_reg(REG_DRIVE_DUTY, 16'hFFFF);
                    write_reg(REG_UNUSED, 16'hFFFF);
                end
                3: begin
                    write_reg(REG_OPEN_TRAVEL, 16'hFFFF);
                    write_reg(REG_CLOSE_TRAVEL, 16'hFFFF);
                    write_reg(REG_DRIVE_DUTY, 16'd512);
                end
                4: begin
                    write_reg(REG_OPEN_TRAVEL, 16'd200);
                    write_reg(REG_CLOSE_TRAVEL, 16'd500);
                    write_reg(REG_DRIVE_DUTY, CFG_DATA_W'($urandom_range(0, 1000)));
                end
                default: begin
                    write_reg(REG_OPEN_TRAVEL, CFG_DATA_W'($urandom_range(100, 400)));
                    write_reg(REG_CLOSE_TRAVEL, CFG_DATA_W'($urandom_range(100, 400)));
                    write_reg(REG_DRIVE_DUTY, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
                end
            endcase
            i_cfg_we <= 1'b0;
            repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, none);
        end

        settle();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
